// ----- hw/rtl/pru_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pru_pkg;

	localparam int CH_W      = 8;
	localparam int PIX_W     = 3 * CH_W;
	localparam int SCALE_W   = 4;
	localparam int WIDTH_W   = 11;
	localparam int CFG_IDX_W = 1;

	localparam int QUEUE_DEPTH = 4;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic FUNC_PIXEL  = 1'b0;
	localparam logic FUNC_REPLAY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'b1;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 4'd2;

	// one queued run: a pixel and how to send its copies
	typedef struct packed {
		logic [PIX_W-1:0]   pix;
		logic [SCALE_W-1:0] scale;
		logic               row_end;
		logic               pending;
	} run_t;

endpackage

`default_nettype wire

// ----- hw/rtl/pru_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pru_in_if;
	logic                    valid;
	logic                    ready;
	logic                    func;
	logic [pru_pkg::CH_W-1:0] red;
	logic [pru_pkg::CH_W-1:0] green;
	logic [pru_pkg::CH_W-1:0] blue;

	modport source (output valid, func, red, green, blue, input ready);
	modport sink   (input valid, func, red, green, blue, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pru_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pru_out_if;
	logic                    valid;
	logic                    ready;
	logic [pru_pkg::CH_W-1:0] out_red;
	logic [pru_pkg::CH_W-1:0] out_green;
	logic [pru_pkg::CH_W-1:0] out_blue;
	logic                    last_copy;
	logic                    row_end;
	logic                    replay_pending;

	modport source (output valid, out_red, out_green, out_blue, last_copy, row_end,
		replay_pending, input ready);
	modport sink   (input valid, out_red, out_green, out_blue, last_copy, row_end,
		replay_pending, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pru_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface pru_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [pru_pkg::CFG_IDX_W-1:0] index;
	logic [pru_pkg::WIDTH_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/pru_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pru_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pru_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pru_front #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	pru_in_if.sink                             in_ch,
	pru_cfg_if.sink                            cfg,
	input  wire logic [pru_pkg::QCNT_W-1:0]    q_count,
	output logic                               push,
	output pru_pkg::run_t                      push_run
);

	localparam int COL_W = MAX_WIDTH > 1 ? $clog2(MAX_WIDTH) : 1;
	localparam int ROW_W = MAX_SCALE > 1 ? $clog2(MAX_SCALE) : 1;
	localparam int WW    = $clog2(MAX_WIDTH + 1) > pru_pkg::WIDTH_W ?
		$clog2(MAX_WIDTH + 1) : pru_pkg::WIDTH_W;

	logic [pru_pkg::SCALE_W-1:0] scale_q;
	logic [pru_pkg::WIDTH_W-1:0] width_q;
	logic [COL_W-1:0]            wcol_q;
	logic [COL_W-1:0]            rcol_q;
	logic [ROW_W-1:0]            rows_q;

	logic                        valid_s1;
	logic                        is_pixel_s1;
	logic [pru_pkg::PIX_W-1:0]   pix_s1;
	logic [pru_pkg::SCALE_W-1:0] scale_s1;
	logic                        row_end_s1;
	logic                        pending_s1;

	logic [pru_pkg::SCALE_W-1:0] eff_s;
	logic [WW-1:0]               eff_w;
	logic [WW-1:0]               wlast;
	logic                        accept;
	logic                        do_pixel;
	logic                        do_replay;
	logic                        wend;
	logic                        rend;
	logic [COL_W-1:0]            waddr;
	logic [COL_W-1:0]            raddr;
	logic [pru_pkg::PIX_W-1:0]   in_pix;
	logic [pru_pkg::PIX_W-1:0]   rdata;

	assign cfg.ready = 1'b1;

	always_comb begin
		if (scale_q == '0) begin
			eff_s = pru_pkg::SCALE_W'(1);
		end else if (int'(scale_q) > MAX_SCALE) begin
			eff_s = pru_pkg::SCALE_W'(MAX_SCALE);
		end else begin
			eff_s = scale_q;
		end
		if (width_q == '0) begin
			eff_w = WW'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(width_q);
		end
	end

	assign wlast = eff_w - WW'(1);

	// columns past the current width count as the last column
	assign wend  = WW'(wcol_q) >= wlast;
	assign rend  = WW'(rcol_q) >= wlast;
	assign waddr = (WW'(wcol_q) >= eff_w) ? COL_W'(wlast) : wcol_q;
	assign raddr = (WW'(rcol_q) >= eff_w) ? COL_W'(wlast) : rcol_q;

	// room for the word in flight plus this one
	assign in_ch.ready = (q_count + pru_pkg::QCNT_W'(valid_s1)) <
		pru_pkg::QCNT_W'(pru_pkg::QUEUE_DEPTH);
	assign accept    = in_ch.valid && in_ch.ready;
	assign do_pixel  = accept && (in_ch.func == pru_pkg::FUNC_PIXEL) && (rows_q == '0);
	assign do_replay = accept && (in_ch.func == pru_pkg::FUNC_REPLAY) && (rows_q != '0);
	assign in_pix    = {in_ch.red, in_ch.green, in_ch.blue};

	pru_ram #(
		.WIDTH (pru_pkg::PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (do_pixel),
		.waddr (waddr),
		.wdata (in_pix),
		.re    (do_replay),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q  <= pru_pkg::SCALE_RESET;
			width_q  <= pru_pkg::WIDTH_W'(MAX_WIDTH);
			wcol_q   <= '0;
			rcol_q   <= '0;
			rows_q   <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					pru_pkg::REG_SCALE:      scale_q <= cfg.data[pru_pkg::SCALE_W-1:0];
					pru_pkg::REG_LINE_WIDTH: width_q <= cfg.data;
					default: ;
				endcase
			end
			valid_s1 <= do_pixel || do_replay;
			if (do_pixel) begin
				if (wend) begin
					wcol_q <= '0;
					rcol_q <= '0;
					rows_q <= ROW_W'(eff_s - pru_pkg::SCALE_W'(1));
				end else begin
					wcol_q <= wcol_q + COL_W'(1);
				end
			end
			if (do_replay) begin
				if (rend) begin
					rcol_q <= '0;
					rows_q <= rows_q - ROW_W'(1);
				end else begin
					rcol_q <= rcol_q + COL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_pixel || do_replay) begin
			is_pixel_s1 <= do_pixel;
			pix_s1      <= in_pix;
			scale_s1    <= eff_s;
			row_end_s1  <= do_pixel ? wend : rend;
			pending_s1  <= do_pixel ? (wend && (eff_s != pru_pkg::SCALE_W'(1)))
				: (!rend || (rows_q != ROW_W'(1)));
		end
	end

	assign push             = valid_s1;
	assign push_run.pix     = is_pixel_s1 ? pix_s1 : rdata;
	assign push_run.scale   = scale_s1;
	assign push_run.row_end = row_end_s1;
	assign push_run.pending = pending_s1;

endmodule

`default_nettype wire

// ----- hw/rtl/pru_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pru_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire pru_pkg::run_t              push_run,
	input  wire logic                       pop,
	output pru_pkg::run_t                   head,
	output logic                            empty,
	output logic [pru_pkg::QCNT_W-1:0]      count
);

	pru_pkg::run_t               slot_q [pru_pkg::QUEUE_DEPTH];
	logic [pru_pkg::QPTR_W-1:0]  wr_q;
	logic [pru_pkg::QPTR_W-1:0]  rd_q;
	logic [pru_pkg::QCNT_W-1:0]  cnt_q;
	logic                        do_pop;

	assign empty  = (cnt_q == '0);
	assign count  = cnt_q;
	assign head   = slot_q[rd_q];
	assign do_pop = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + pru_pkg::QPTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + pru_pkg::QPTR_W'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + pru_pkg::QCNT_W'(1);
			end else if (!push && do_pop) begin
				cnt_q <= cnt_q - pru_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_run;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pru_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pru_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire pru_pkg::run_t head,
	input  wire logic          empty,
	output logic               pop,
	pru_out_if.source          out_ch
);

	logic [pru_pkg::SCALE_W-1:0] copy_q;
	logic                        out_valid_q;
	logic                        load;
	logic                        is_last;

	assign load    = !out_valid_q || out_ch.ready;
	assign is_last = (copy_q == head.scale - pru_pkg::SCALE_W'(1));
	assign pop     = load && !empty && is_last;

	assign out_ch.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			copy_q      <= '0;
		end else if (load) begin
			out_valid_q <= !empty;
			if (!empty) begin
				copy_q <= is_last ? '0 : copy_q + pru_pkg::SCALE_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && !empty) begin
			out_ch.out_red        <= head.pix[3*pru_pkg::CH_W-1:2*pru_pkg::CH_W];
			out_ch.out_green      <= head.pix[2*pru_pkg::CH_W-1:pru_pkg::CH_W];
			out_ch.out_blue       <= head.pix[pru_pkg::CH_W-1:0];
			out_ch.last_copy      <= is_last;
			out_ch.row_end        <= head.row_end;
			out_ch.replay_pending <= head.pending;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/pixel_replicate_upscaler.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbor RGB upscaler with a one-line store. A pixel word (func 0) is
// written to the line store and sent out scale times; after the last pixel of a
// line, scale-1 passes of replay words (func 1) each send one stored pixel scale
// times; pixel words that arrive during those passes are dropped, as are replay
// words outside them. Input words are taken every cycle while the four-entry
// run queue has room; output copies leave at one per cycle while out_ch.ready
// allows, so the output register sets the sustained rate. A first copy passes
// the front stage register, the run queue and the output register. The user
// must write scale and line_width only while idle; the block does not check it.
module pixel_replicate_upscaler #(
	parameter int MAX_WIDTH = 1024,
	parameter int MAX_SCALE = 8
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pru_in_if.sink    in_ch,
	pru_out_if.source out_ch,
	pru_cfg_if.sink   cfg
);

	logic                       push;
	pru_pkg::run_t              push_run;
	pru_pkg::run_t              head;
	logic                       empty;
	logic                       pop;
	logic [pru_pkg::QCNT_W-1:0] q_count;

	pru_front #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_SCALE (MAX_SCALE)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.cfg      (cfg),
		.q_count  (q_count),
		.push     (push),
		.push_run (push_run)
	);

	pru_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_run (push_run),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.count    (q_count)
	);

	pru_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (empty),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

`default_nettype wire

// ----- sim/tb_pixel_replicate_upscaler.sv -----
`timescale 1ns / 1ps

module tb_pixel_replicate_upscaler;

	localparam int MAX_WIDTH     = 1024;
	localparam int MAX_SCALE     = 8;
	localparam int TOTAL_WORDS   = 460;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 150;
	localparam int LIMIT_NS      = 400_000;
	localparam int DIR_ROWS      = 27;

	typedef struct packed {
		logic [pru_pkg::PIX_W-1:0] pix;
		logic                      last_copy;
		logic                      row_end;
		logic                      pending;
	} copy_t;

	// directed row: either a register write or an input word, optionally with
	// a hand-written expectation instead of the predictor's
	typedef struct {
		bit                            is_reg;
		logic [pru_pkg::CFG_IDX_W-1:0] idx;
		logic [pru_pkg::WIDTH_W-1:0]   data;
		logic                          func;
		logic [pru_pkg::PIX_W-1:0]     pix;
		bit                            typed;
		int                            n;
		bit                            row_end;
		bit                            pending;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	pru_in_if  in_ch();
	pru_out_if out_ch();
	pru_cfg_if cfg_ch();

	pixel_replicate_upscaler u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg    (cfg_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// upscaler state as predicted
	logic [pru_pkg::PIX_W-1:0]   line_mem [MAX_WIDTH];
	int                          wr_col;
	int                          rp_col;
	logic [2:0]                  rows_left;
	logic [pru_pkg::SCALE_W-1:0] scale_q;
	logic [pru_pkg::WIDTH_W-1:0] width_q;

	copy_t copies_due [$];
	int    mismatch_count = 0;
	int    words_sent = 0;
	bit    calm = 1'b0;
	bit    long_hold = 1'b0;

	dir_row_t steps [DIR_ROWS] = '{
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_PIXEL, 24'hFF0080, 1'b1, 2, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'h000000, 1'b1, 0, 1'b0, 1'b0},
		// width shrinks mid-line, so the next pixel closes the line
		'{1'b1, pru_pkg::REG_LINE_WIDTH, 11'd2, pru_pkg::FUNC_PIXEL, 24'h0, 1'b0, 0, 1'b0, 1'b0},
		'{1'b1, pru_pkg::REG_SCALE, 11'd3, pru_pkg::FUNC_PIXEL, 24'h0, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_PIXEL, 24'h00FF00, 1'b1, 3, 1'b1, 1'b1},
		// pixel during replay is dropped
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_PIXEL, 24'h123456, 1'b1, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'hABCDEF, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'h000000, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'hFFFFFF, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'h5A5A5A, 1'b0, 0, 1'b0, 1'b0},
		// scale zero acts as one, no replay armed
		'{1'b1, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_PIXEL, 24'h0, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_PIXEL, 24'hFFFFFF, 1'b1, 1, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_PIXEL, 24'h000000, 1'b1, 1, 1'b1, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'hFFFFFF, 1'b1, 0, 1'b0, 1'b0},
		// scale saturates to the max, width zero acts as one
		'{1'b1, pru_pkg::REG_SCALE, 11'd15, pru_pkg::FUNC_PIXEL, 24'h0, 1'b0, 0, 1'b0, 1'b0},
		'{1'b1, pru_pkg::REG_LINE_WIDTH, 11'd0, pru_pkg::FUNC_PIXEL, 24'h0, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_PIXEL, 24'h010203, 1'b1, 8, 1'b1, 1'b1},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'h000000, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'hFFFFFF, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'h000000, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'hFFFFFF, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'h000000, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'hFFFFFF, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_REPLAY, 24'h000000, 1'b0, 0, 1'b0, 1'b0},
		// width saturates, scale ignores upper data bits
		'{1'b1, pru_pkg::REG_LINE_WIDTH, 11'd2047, pru_pkg::FUNC_PIXEL, 24'h0, 1'b0, 0, 1'b0,
			1'b0},
		'{1'b1, pru_pkg::REG_SCALE, 11'h7F3, pru_pkg::FUNC_PIXEL, 24'h0, 1'b0, 0, 1'b0, 1'b0},
		'{1'b0, pru_pkg::REG_SCALE, 11'd0, pru_pkg::FUNC_PIXEL, 24'h5AA5C3, 1'b1, 3, 1'b0, 1'b0}
	};

	function automatic int active_scale();
		int s;
		s = scale_q;
		if (s == 0) s = 1;
		if (s > MAX_SCALE) s = MAX_SCALE;
		return s;
	endfunction

	function automatic int active_width();
		int w;
		w = width_q;
		if (w == 0) w = 1;
		if (w > MAX_WIDTH) w = MAX_WIDTH;
		return w;
	endfunction

	function automatic void push_copies(input logic [pru_pkg::PIX_W-1:0] pix, input int n,
		input bit row_end, input bit pending);
		copy_t c;
		for (int k = 0; k < n; k++) begin
			c.pix       = pix;
			c.last_copy = (k == n - 1);
			c.row_end   = row_end;
			c.pending   = pending;
			copies_due.push_back(c);
		end
	endfunction

	// advances the line state for one accepted word, returns the copy count
	function automatic int replicate_word(input logic f,
		input logic [pru_pkg::PIX_W-1:0] pix_in, input bit push);
		int                        s;
		int                        w;
		int                        col;
		logic [pru_pkg::PIX_W-1:0] pix;
		bit                        at_end;
		s = active_scale();
		w = active_width();
		if (f == pru_pkg::FUNC_PIXEL) begin
			if (rows_left != 0) return 0;
			col = (wr_col >= w) ? w - 1 : wr_col;
			line_mem[col] = pix_in;
			pix = pix_in;
			at_end = (wr_col >= w - 1);
			if (at_end) begin
				wr_col = 0;
				rp_col = 0;
				rows_left = 3'(s - 1);
			end else begin
				wr_col++;
			end
		end else begin
			if (rows_left == 0) return 0;
			col = (rp_col >= w) ? w - 1 : rp_col;
			pix = line_mem[col];
			at_end = (rp_col >= w - 1);
			if (at_end) begin
				rp_col = 0;
				rows_left--;
			end else begin
				rp_col++;
			end
		end
		if (push) push_copies(pix, s, at_end, rows_left != 0);
		return s;
	endfunction

	task automatic send_word(input logic f, input logic [pru_pkg::PIX_W-1:0] pix,
		input bit push, output int n);
		while (!calm && $urandom_range(99) < 6) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.func  <= f;
		in_ch.red   <= pix[23:16];
		in_ch.green <= pix[15:8];
		in_ch.blue  <= pix[7:0];
		do @(posedge clk); while (!in_ch.ready);
		n = replicate_word(f, pix, push);
	endtask

	// wait until every expected copy is out, plus time for dropped words
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (copies_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [pru_pkg::CFG_IDX_W-1:0] idx,
		input logic [pru_pkg::WIDTH_W-1:0] value);
		drain();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		if (idx == pru_pkg::REG_SCALE) scale_q = value[pru_pkg::SCALE_W-1:0];
		else width_q = value;
	endtask

	// output side: random stalls, plus one long hold-off on request
	initial begin
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_hold = 1'b0;
			end
			out_ch.ready <= calm || ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		copy_t got;
		copy_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			got.pix       = {out_ch.out_red, out_ch.out_green, out_ch.out_blue};
			got.last_copy = out_ch.last_copy;
			got.row_end   = out_ch.row_end;
			got.pending   = out_ch.replay_pending;
			if (copies_due.size() == 0) begin
				if (mismatch_count < 10)
					$display("%0t: unexpected word pix=%h last=%b end=%b pend=%b", $realtime,
						got.pix, got.last_copy, got.row_end, got.pending);
				mismatch_count++;
			end else begin
				want = copies_due.pop_front();
				if (got !== want) begin
					if (mismatch_count < 10)
						$display("%0t: want pix=%h l/e/p=%b%b%b, got pix=%h l/e/p=%b%b%b",
							$realtime, want.pix, want.last_copy, want.row_end, want.pending,
							got.pix, got.last_copy, got.row_end, got.pending);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("tb_pixel_replicate_upscaler: done, errors");
		$finish;
	end

	initial begin
		int   n;
		int   phase;
		int   burst;
		int   pick;
		int   s_val;
		int   w_val;
		logic f;
		arst_n       <= 1'b0;
		in_ch.valid  <= 1'b0;
		in_ch.func   <= pru_pkg::FUNC_PIXEL;
		in_ch.red    <= '0;
		in_ch.green  <= '0;
		in_ch.blue   <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= pru_pkg::REG_SCALE;
		cfg_ch.data  <= '0;
		wr_col    = 0;
		rp_col    = 0;
		rows_left = '0;
		scale_q   = pru_pkg::SCALE_RESET;
		width_q   = pru_pkg::WIDTH_W'(MAX_WIDTH);
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i]) begin
			if (steps[i].is_reg) begin
				write_reg(steps[i].idx, steps[i].data);
			end else begin
				send_word(steps[i].func, steps[i].pix, !steps[i].typed, n);
				if (steps[i].typed) begin
					push_copies(steps[i].pix, steps[i].n, steps[i].row_end, steps[i].pending);
					n = steps[i].n;
				end
				if (n > 0) words_sent++;
			end
		end

		phase = 0;
		while (words_sent < TOTAL_WORDS) begin
			phase++;
			calm = (phase >= 5 && phase <= 7);
			pick = $urandom_range(99);
			if (pick < 8) s_val = 0;
			else if (pick < 18) s_val = MAX_SCALE;
			else if (pick < 24) s_val = $urandom_range(15, 9);
			else s_val = $urandom_range(4, 1);
			write_reg(pru_pkg::REG_SCALE, {($urandom_range(3) == 0) ? 7'($urandom) : 7'd0,
				4'(s_val)});
			// width only moves with no replay armed, so replay never reads a
			// column this line has not written
			if (rows_left == 0) begin
				pick = $urandom_range(99);
				if (pick < 5) w_val = 0;
				else if (pick < 9) w_val = $urandom_range(2047, 1025);
				else if (pick < 12) w_val = MAX_WIDTH;
				else if (pick < 20) w_val = $urandom_range(40, 9);
				else w_val = $urandom_range(8, 1);
				write_reg(pru_pkg::REG_LINE_WIDTH, pru_pkg::WIDTH_W'(w_val));
			end
			burst = $urandom_range(30, 8);
			if (phase == 2) long_hold = 1'b1;
			for (int i = 0; i < burst; i++) begin
				if (phase == 3 && i == burst / 2) drain();
				f = (rows_left != 0) ? pru_pkg::FUNC_REPLAY : pru_pkg::FUNC_PIXEL;
				if ($urandom_range(99) < 10) f = ~f;
				send_word(f, pru_pkg::PIX_W'($urandom), 1'b1, n);
				if (n > 0) words_sent++;
			end
		end

		drain();
		if (mismatch_count == 0)
			$display("tb_pixel_replicate_upscaler: done, clean");
		else
			$display("tb_pixel_replicate_upscaler: done, errors");
		$finish;
	end

endmodule
